// ----- hdl/missing_packet_retry_table_core_defines.svh -----
// ----------------------------------------------------------------------------
// Retry table assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MISSING_PACKET_RETRY_TABLE_CORE_DEFINES_SVH
`define MISSING_PACKET_RETRY_TABLE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// The condition must hold at every clock edge outside reset.
`define MPRT_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("retry table assertion failed");
// When the trigger holds, the condition must hold in the following cycle.
`define MPRT_ASSERT_NXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("retry table assertion failed");
`else
`define MPRT_ASSERT(label, cond)
`define MPRT_ASSERT_NXT(label, trig, cond)
`endif
`endif

// ----- hdl/mprt_pkg.sv -----
// ----------------------------------------------------------------------------
// Retry table package
// Item types, table entry layout, operation codes and register constants.
// ----------------------------------------------------------------------------
package mprt_pkg;

  // Operation codes carried in the operation field of an input item.
  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_SERVICE = 2'd1;
  localparam logic [1:0] OP_CONFIRM = 2'd2;

  // Configuration register indexes (selected by paddr[2]).
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_MAX_ATT = 1'b1;

  localparam logic [31:0] TIMEOUT_RST = 32'd10000;
  localparam logic [2:0]  MAX_ATT_RST = 3'd5;
  localparam logic [2:0]  ATT_SAT     = 3'd7;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] pkt_seq;
    logic [31:0] now_us;
    logic        radio_busy;
  } in_item_t;

  typedef struct packed {
    logic        retry_valid;
    logic [15:0] retry_sequence;
    logic [2:0]  attempt_number;
    logic        add_dropped;
  } out_item_t;

  // One table slot as held in the slot memory.
  typedef struct packed {
    logic        used;
    logic        delete_mark;
    logic [2:0]  attempts;
    logic [31:0] slot_time;
    logic [15:0] pkt_seq;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CLEAR  = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_t;

endpackage

// ----- hdl/missing_packet_retry_table_core.sv -----
// ----------------------------------------------------------------------------
// Missing packet retry table
// Table of missing sequence numbers awaiting retransmission, with add,
// service and confirm operations walked over a slot memory one slot a cycle.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. An add, a confirm and
// a service with the radio free keep busy high while they walk the slot
// memory; the single result item is then shown on out_item for exactly one
// cycle with out_valid high, in the cycle in which busy falls. It cannot be
// held off, so the receiver must take it in that cycle. The walk reads one
// slot per cycle through the memory's single registered read port. A
// service with the radio free issues the first read, checks every slot in
// turn and then writes back the chosen slot; if no slot survives, it
// answers at the last check instead. An add or confirm finishes at the
// first matching slot, and at worst at the last slot. busy is already low
// in the result cycle, so the next item can be taken at the edge that
// ends it. A service with radio_busy set, and an unused operation code,
// give an all-zero result in the cycle after start without raising busy.
// After reset the block clears the slot memory, one slot a cycle, with
// busy high; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
`include "missing_packet_retry_table_core_defines.svh"

module missing_packet_retry_table_core #(
  parameter int ENTRIES = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  mprt_pkg::in_item_t  in_item,
  output logic                busy,
  output logic                out_valid,
  output mprt_pkg::out_item_t out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // Sequencer and walk state.
  mprt_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0] scan_addr_r, scan_addr_nxt;
  logic             chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0] chk_idx_r;

  // The accepted item, held for the length of the walk.
  logic [1:0]  op_r, op_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic [31:0] now_r, now_nxt;

  // Oldest surviving slot found so far during a service walk.
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic [31:0]      best_time_r, best_time_nxt;
  logic [15:0]      best_seq_r, best_seq_nxt;
  logic [2:0]       best_att_r, best_att_nxt;

  logic [31:0] timeout_r;
  logic [2:0]  max_att_r;

  logic                out_valid_r, out_valid_nxt;
  mprt_pkg::out_item_t out_item_r, out_item_nxt;

  // Memory port signals.
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  mprt_pkg::entry_t wr_data;
  mprt_pkg::entry_t rd_data;

  // Shared slot evaluation unit.
  logic [31:0] age;
  logic        expired;
  logic        survivor;
  logic        better;
  logic        chk_last;
  logic        cfg_wr;
  logic [2:0]  att_inc;

  mprt_store #(
    .DEPTH (ENTRIES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (scan_addr_r),
    .rd_data (rd_data)
  );

  // The age is taken modulo 2^32, so a wrapped clock still ages correctly.
  assign age      = now_r - rd_data.slot_time;
  assign expired  = rd_data.used && ((age >= timeout_r) || (rd_data.attempts >= max_att_r) ||
                                     rd_data.delete_mark);
  assign survivor = rd_data.used && !expired;
  // Strict less-than keeps the lowest index on equal timestamps.
  assign better   = survivor && (!found_r || (rd_data.slot_time < best_time_r));
  assign chk_last = (chk_idx_r == LAST_IDX);
  assign att_inc  = (best_att_r == mprt_pkg::ATT_SAT) ? best_att_r : best_att_r + 3'd1;

  always_comb begin
    state_nxt     = state_r;
    scan_addr_nxt = scan_addr_r;
    op_nxt        = op_r;
    seq_nxt       = seq_r;
    now_nxt       = now_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_time_nxt = best_time_r;
    best_seq_nxt  = best_seq_r;
    best_att_nxt  = best_att_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    wr_en         = 1'b0;
    wr_addr       = chk_idx_r;
    wr_data       = '0;

    unique case (state_r)
      mprt_pkg::ST_CLEAR: begin
        // Write every slot back to its empty value after reset.
        wr_en   = 1'b1;
        wr_addr = scan_addr_r;
        if (scan_addr_r == LAST_IDX) begin
          scan_addr_nxt = '0;
          state_nxt     = mprt_pkg::ST_IDLE;
        end else begin
          scan_addr_nxt = scan_addr_r + 1'b1;
        end
      end

      mprt_pkg::ST_IDLE: begin
        if (start) begin
          op_nxt        = in_item.operation;
          seq_nxt       = in_item.pkt_seq;
          now_nxt       = in_item.now_us;
          found_nxt     = 1'b0;
          scan_addr_nxt = '0;
          if ((in_item.operation == mprt_pkg::OP_SERVICE && in_item.radio_busy) ||
              !(in_item.operation == mprt_pkg::OP_ADD ||
                in_item.operation == mprt_pkg::OP_SERVICE ||
                in_item.operation == mprt_pkg::OP_CONFIRM)) begin
            // Nothing to do: report an empty result at once.
            out_valid_nxt = 1'b1;
            out_item_nxt  = '0;
          end else begin
            state_nxt = mprt_pkg::ST_SCAN;
          end
        end
      end

      mprt_pkg::ST_SCAN: begin
        scan_addr_nxt = (scan_addr_r == LAST_IDX) ? '0 : scan_addr_r + 1'b1;
        if (chk_vld_r) begin
          unique case (op_r)
            mprt_pkg::OP_ADD: begin
              if (!rd_data.used) begin
                wr_en             = 1'b1;
                wr_data.used      = 1'b1;
                wr_data.slot_time = now_r;
                wr_data.pkt_seq   = seq_r;
                out_valid_nxt     = 1'b1;
                out_item_nxt      = '0;
                state_nxt         = mprt_pkg::ST_IDLE;
              end else if (chk_last) begin
                out_valid_nxt            = 1'b1;
                out_item_nxt             = '0;
                out_item_nxt.add_dropped = 1'b1;
                state_nxt                = mprt_pkg::ST_IDLE;
              end
            end

            mprt_pkg::OP_CONFIRM: begin
              if (rd_data.used && (rd_data.pkt_seq == seq_r)) begin
                wr_en               = 1'b1;
                wr_data             = rd_data;
                wr_data.delete_mark = 1'b1;
                out_valid_nxt       = 1'b1;
                out_item_nxt        = '0;
                state_nxt           = mprt_pkg::ST_IDLE;
              end else if (chk_last) begin
                out_valid_nxt = 1'b1;
                out_item_nxt  = '0;
                state_nxt     = mprt_pkg::ST_IDLE;
              end
            end

            mprt_pkg::OP_SERVICE: begin
              // Cleanup and the oldest-slot search share one walk.
              if (expired) begin
                wr_en = 1'b1;
              end
              if (better) begin
                found_nxt     = 1'b1;
                best_idx_nxt  = chk_idx_r;
                best_time_nxt = rd_data.slot_time;
                best_seq_nxt  = rd_data.pkt_seq;
                best_att_nxt  = rd_data.attempts;
              end
              if (chk_last) begin
                if (found_nxt) begin
                  state_nxt = mprt_pkg::ST_UPDATE;
                end else begin
                  out_valid_nxt = 1'b1;
                  out_item_nxt  = '0;
                  state_nxt     = mprt_pkg::ST_IDLE;
                end
              end
            end

            default: begin
              state_nxt = mprt_pkg::ST_IDLE;
            end
          endcase
        end
      end

      mprt_pkg::ST_UPDATE: begin
        // The chosen slot survived cleanup, so its delete mark is clear.
        wr_en                       = 1'b1;
        wr_addr                     = best_idx_r;
        wr_data.used                = 1'b1;
        wr_data.attempts            = att_inc;
        wr_data.slot_time           = best_time_r;
        wr_data.pkt_seq             = best_seq_r;
        out_valid_nxt               = 1'b1;
        out_item_nxt                = '0;
        out_item_nxt.retry_valid    = 1'b1;
        out_item_nxt.retry_sequence = best_seq_r;
        out_item_nxt.attempt_number = att_inc;
        state_nxt                   = mprt_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = mprt_pkg::ST_IDLE;
      end
    endcase
  end

  // Read data is valid in the cycle after its address while the walk goes on.
  assign chk_vld_nxt = (state_r == mprt_pkg::ST_SCAN) && (state_nxt == mprt_pkg::ST_SCAN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mprt_pkg::ST_CLEAR;
      scan_addr_r <= '0;
      chk_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_addr_r <= scan_addr_nxt;
      chk_vld_r   <= chk_vld_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r   <= scan_addr_r;
    op_r        <= op_nxt;
    seq_r       <= seq_nxt;
    now_r       <= now_nxt;
    best_idx_r  <= best_idx_nxt;
    best_time_r <= best_time_nxt;
    best_seq_r  <= best_seq_nxt;
    best_att_r  <= best_att_nxt;
    out_item_r  <= out_item_nxt;
  end

  // Configuration registers. Writes complete in the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= mprt_pkg::TIMEOUT_RST;
      max_att_r <= mprt_pkg::MAX_ATT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        mprt_pkg::REG_TIMEOUT: timeout_r <= pwdata;
        mprt_pkg::REG_MAX_ATT: max_att_r <= pwdata[2:0];
        default:               timeout_r <= timeout_r;
      endcase
    end
  end

  assign prdata = (paddr[2] == mprt_pkg::REG_MAX_ATT) ? 32'(max_att_r) : timeout_r;

  assign busy      = (state_r != mprt_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // An accepted item either answers at once or keeps the block busy.
  `MPRT_ASSERT_NXT(a_accept_progress, start && !busy, busy || out_valid)
  // A result only appears as the block returns to idle.
  `MPRT_ASSERT(a_result_when_idle, !out_valid || !busy)
  // A resend request and a dropped add never share a result.
  `MPRT_ASSERT(a_result_exclusive,
               !(out_valid && out_item.retry_valid && out_item.add_dropped))
  // A resend always carries a non-zero attempt count.
  `MPRT_ASSERT(a_retry_attempt, !(out_valid && out_item.retry_valid) ||
               (out_item.attempt_number != 3'd0))
  // Slot writes stay inside the table.
  `MPRT_ASSERT(a_wr_in_range, !wr_en || (wr_addr <= LAST_IDX))

endmodule

// ----- hdl/mprt_store.sv -----
// ----------------------------------------------------------------------------
// Retry table slot store
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module mprt_store #(
  parameter int DEPTH = 128
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [$clog2(DEPTH)-1:0]  wr_addr,
  input  mprt_pkg::entry_t          wr_data,
  input  logic [$clog2(DEPTH)-1:0]  rd_addr,
  output mprt_pkg::entry_t          rd_data
);

  mprt_pkg::entry_t mem [DEPTH];
  mprt_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- tb/tb_missing_packet_retry_table_core.sv -----
// ----------------------------------------------------------------------------
// Retry table core testbench
// Drives add, service, confirm and unused-code items through the command
// port, keeps a behavioural copy of the retry table, and checks every
// result item field by field. A short table of directed items comes
// first. Random items follow, over several register settings with extremes.
// ----------------------------------------------------------------------------
module tb_missing_packet_retry_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          TABLE_DEPTH = 128;
  localparam int          STALL_LIMIT = 2000;
  localparam int          DRAIN_WAIT  = 140;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam int          PHASES      = 6;

  // One row of the directed plan. When known_zero is set the expected result
  // is the all-zero item, which can be read straight off the behaviour.
  typedef struct {
    mprt_pkg::in_item_t stim;
    bit                 known_zero;
  } plan_row_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  mprt_pkg::in_item_t  in_item;
  logic                busy;
  logic                out_valid;
  mprt_pkg::out_item_t out_item;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  // Behavioural copy of the slot store and of the two registers.
  bit          tbl_used [TABLE_DEPTH];
  logic [15:0] tbl_seq  [TABLE_DEPTH];
  logic [31:0] tbl_time [TABLE_DEPTH];
  logic [2:0]  tbl_att  [TABLE_DEPTH];
  bit          tbl_del  [TABLE_DEPTH];
  logic [31:0] cur_timeout;
  logic [2:0]  cur_max_att;

  mprt_pkg::out_item_t awaited_results[$];
  plan_row_t           plan_rows[$];
  logic [15:0]         seq_pool[$];
  int                  fail_count;
  int                  stall_cycles;
  bit                  idle_enable;

  missing_packet_retry_table_core #(.ENTRIES(TABLE_DEPTH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // 10 ns clock; the clock is known from time zero.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Works out the result of one item and applies its effect on the table.
  // A service first sweeps out expired, exhausted and confirmed slots, then
  // picks the oldest stored time, the lowest slot winning a tie. The age is
  // taken modulo 2^32, so a time that has wrapped still ages correctly.
  function automatic mprt_pkg::out_item_t retry_result(input mprt_pkg::in_item_t it);
    mprt_pkg::out_item_t r;
    logic [31:0]         age;
    logic [31:0]         best_time;
    int                  best;
    bit                  found;
    r         = '0;
    found     = 1'b0;
    best      = 0;
    best_time = '0;
    case (it.operation)
      mprt_pkg::OP_ADD: begin
        for (int i = 0; i < TABLE_DEPTH && !found; i++) begin
          if (!tbl_used[i]) begin
            tbl_used[i] = 1'b1;
            tbl_seq[i]  = it.pkt_seq;
            tbl_time[i] = it.now_us;
            tbl_att[i]  = '0;
            tbl_del[i]  = 1'b0;
            found       = 1'b1;
          end
        end
        r.add_dropped = !found;
      end
      mprt_pkg::OP_SERVICE: begin
        if (!it.radio_busy) begin
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            age = it.now_us - tbl_time[i];
            if (tbl_used[i] && (age >= cur_timeout || tbl_att[i] >= cur_max_att ||
                                tbl_del[i])) begin
              tbl_used[i] = 1'b0;
              tbl_seq[i]  = '0;
              tbl_time[i] = '0;
              tbl_att[i]  = '0;
              tbl_del[i]  = 1'b0;
            end
          end
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (tbl_used[i] && (!found || tbl_time[i] < best_time)) begin
              found     = 1'b1;
              best      = i;
              best_time = tbl_time[i];
            end
          end
          if (found) begin
            // The attempt count stops at its top value rather than wrapping.
            if (tbl_att[best] != mprt_pkg::ATT_SAT) tbl_att[best] = tbl_att[best] + 3'd1;
            r.retry_valid    = 1'b1;
            r.retry_sequence = tbl_seq[best];
            r.attempt_number = tbl_att[best];
          end
        end
      end
      mprt_pkg::OP_CONFIRM: begin
        // Only the first used slot holding the sequence is marked.
        for (int i = 0; i < TABLE_DEPTH && !found; i++) begin
          if (tbl_used[i] && tbl_seq[i] == it.pkt_seq) begin
            tbl_del[i] = 1'b1;
            found      = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic void plan_row(input logic [1:0] op, input logic [15:0] seq,
                                   input logic [31:0] stamp, input logic radio,
                                   input bit known_zero);
    plan_row_t row;
    row.stim.operation  = op;
    row.stim.pkt_seq    = seq;
    row.stim.now_us     = stamp;
    row.stim.radio_busy = radio;
    row.known_zero      = known_zero;
    plan_rows.push_back(row);
  endfunction

  // Presents one item and waits for the block to take it. Idle cycles are
  // inserted at random falling edges; start is only ever assigned once per
  // edge, so a start that stays high for the next item is never pulsed.
  task automatic send_item(input mprt_pkg::in_item_t it, input bit known_zero);
    mprt_pkg::out_item_t predicted;
    bit                  placed;
    placed = 1'b0;
    while (!placed) begin
      @(negedge clk);
      if (idle_enable && $urandom_range(99) < 22) begin
        start <= 1'b0;
      end else begin
        start   <= 1'b1;
        in_item <= it;
        placed  = 1'b1;
      end
    end
    do @(posedge clk); while (busy);
    predicted = retry_result(it);
    awaited_results.push_back(known_zero ? mprt_pkg::out_item_t'('0) : predicted);
  endtask

  // Lowers start and waits until every awaited result has come back and the
  // block has gone quiet, so that the registers may be rewritten.
  task automatic drain_block();
    @(negedge clk);
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy);
  endtask

  // Register write: a setup cycle then an access cycle.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == mprt_pkg::REG_TIMEOUT) cur_timeout = value;
    else cur_max_att = value[2:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Result checker: each strobed result is compared with the oldest
  // awaited item. The receiver cannot stall, so every strobe is taken.
  always @(posedge clk) begin : check_results
    mprt_pkg::out_item_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (awaited_results.size() == 0) begin
        $error("result item with nothing awaited: %h", out_item);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_item.retry_valid !== want.retry_valid) begin
          $error("retry_valid: expected %0d, got %0d", want.retry_valid,
                 out_item.retry_valid);
          fail_count++;
        end
        if (out_item.retry_sequence !== want.retry_sequence) begin
          $error("retry_sequence: expected %h, got %h", want.retry_sequence,
                 out_item.retry_sequence);
          fail_count++;
        end
        if (out_item.attempt_number !== want.attempt_number) begin
          $error("attempt_number: expected %0d, got %0d", want.attempt_number,
                 out_item.attempt_number);
          fail_count++;
        end
        if (out_item.add_dropped !== want.add_dropped) begin
          $error("add_dropped: expected %0d, got %0d", want.add_dropped,
                 out_item.add_dropped);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: the run is abandoned when nothing moves on either side for
  // far longer than the slowest item, the clearing pass after reset and a
  // register update put together.
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("missing_packet_retry_table_core: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0]        phase_timeout [PHASES];
    logic [2:0]         phase_att     [PHASES];
    int                 phase_items   [PHASES];
    int                 phase_add_pct [PHASES];
    mprt_pkg::in_item_t it;
    logic [31:0]        clock_us;
    int                 rand_index;
    int                 roll;
    int                 svc_cut;
    phase_timeout = '{32'hFFFF_FFFF, 32'd1, 32'd0, 32'd20000, 32'd500, 32'h8000_0000};
    phase_att     = '{3'd7, 3'd1, 3'd4, 3'd0, 3'd3, 3'd2};
    phase_items   = '{250, 150, 150, 150, 160, 160};
    phase_add_pct = '{75, 45, 45, 45, 45, 45};
    start        = 1'b0;
    in_item      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    rst_n        = 1'b0;
    idle_enable  = 1'b1;
    fail_count   = 0;
    stall_cycles = 0;
    rand_index   = 0;
    cur_timeout  = mprt_pkg::TIMEOUT_RST;
    cur_max_att  = mprt_pkg::MAX_ATT_RST;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_used[i] = 1'b0;
      tbl_seq[i]  = '0;
      tbl_time[i] = '0;
      tbl_att[i]  = '0;
      tbl_del[i]  = 1'b0;
    end

    // Directed plan, run at the reset register values. A service on the
    // empty table, the unused code and a busy radio all give a zero item.
    plan_row(mprt_pkg::OP_SERVICE, 16'h0000, 32'h0000_0000, 1'b0, 1'b1);
    plan_row(OP_UNUSED,            16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
    plan_row(mprt_pkg::OP_ADD,     16'hFFFF, 32'hFFFF_FFFF, 1'b0, 1'b1);
    plan_row(mprt_pkg::OP_ADD,     16'h0000, 32'h0000_0000, 1'b1, 1'b1);
    plan_row(mprt_pkg::OP_SERVICE, 16'h0000, 32'd5,         1'b1, 1'b1);
    // Oldest stored time first; the wrapped age of the top timestamp is small.
    plan_row(mprt_pkg::OP_SERVICE, 16'h0000, 32'd5,         1'b0, 1'b0);
    // A confirm that matches nothing, then one that marks a slot.
    plan_row(mprt_pkg::OP_CONFIRM, 16'h1234, 32'd6,         1'b0, 1'b1);
    plan_row(mprt_pkg::OP_CONFIRM, 16'h0000, 32'd7,         1'b0, 1'b1);
    // The slot holding the largest timestamp is now the only candidate.
    plan_row(mprt_pkg::OP_SERVICE, 16'h0000, 32'd10,        1'b0, 1'b0);
    for (int i = 0; i < 5; i++) begin
      plan_row(mprt_pkg::OP_SERVICE, 16'hFFFF, 32'd11 + i, 1'b0, 1'b0);
    end
    // Duplicate sequences: the confirm marks only the first of the two.
    plan_row(mprt_pkg::OP_ADD,     16'h00AA, 32'd100,       1'b0, 1'b1);
    plan_row(mprt_pkg::OP_ADD,     16'h00AA, 32'd200,       1'b0, 1'b1);
    plan_row(mprt_pkg::OP_CONFIRM, 16'h00AA, 32'd250,       1'b0, 1'b1);
    plan_row(mprt_pkg::OP_SERVICE, 16'h0000, 32'd300,       1'b0, 1'b0);
    // An age exactly equal to the timeout frees the slot.
    plan_row(mprt_pkg::OP_SERVICE, 16'h0000, 32'd10200,     1'b0, 1'b0);
    plan_row(mprt_pkg::OP_ADD,     16'h5A5A, 32'h7FFF_FFFF, 1'b0, 1'b1);
    plan_row(mprt_pkg::OP_SERVICE, 16'h5A5A, 32'h7FFF_FFFF, 1'b1, 1'b1);
    plan_row(mprt_pkg::OP_SERVICE, 16'hA5A5, 32'h8000_0000, 1'b0, 1'b0);

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan_rows[k]) send_item(plan_rows[k].stim, plan_rows[k].known_zero);

    // Random part, one register setting per phase. The first phase keeps
    // slots alive and adds heavily so that the table fills and adds drop.
    clock_us = $urandom;
    for (int p = 0; p < PHASES; p++) begin
      drain_block();
      write_reg(mprt_pkg::REG_TIMEOUT, phase_timeout[p]);
      write_reg(mprt_pkg::REG_MAX_ATT, {29'd0, phase_att[p]});
      svc_cut = phase_add_pct[p] + 2 + ((98 - phase_add_pct[p]) * 2) / 3;
      for (int n = 0; n < phase_items[p]; n++) begin
        // A long stretch with no idling at all in the middle of the run.
        idle_enable = (rand_index < 400 || rand_index >= 560);
        rand_index++;

        // Time mostly creeps forward, sometimes leaps and wraps, and now
        // and then jumps anywhere, backwards included.
        roll = $urandom_range(99);
        if (roll < 88) clock_us = clock_us + $urandom_range(300);
        else if (roll < 97) clock_us = clock_us + $urandom;
        else clock_us = $urandom;

        it.now_us     = clock_us;
        it.pkt_seq    = 16'($urandom_range(16'hFFFF));
        it.radio_busy = 1'($urandom_range(1));
        roll = $urandom_range(99);
        if (roll < phase_add_pct[p]) begin
          it.operation = mprt_pkg::OP_ADD;
          if ($urandom_range(99) < 30) it.pkt_seq = 16'($urandom_range(15));
          seq_pool.push_back(it.pkt_seq);
          if (seq_pool.size() > 64) void'(seq_pool.pop_front());
        end else if (roll < phase_add_pct[p] + 2) begin
          it.operation = OP_UNUSED;
        end else if (roll < svc_cut) begin
          it.operation  = mprt_pkg::OP_SERVICE;
          it.radio_busy = ($urandom_range(99) < 15);
        end else begin
          it.operation = mprt_pkg::OP_CONFIRM;
          if (seq_pool.size() != 0 && $urandom_range(99) < 80) begin
            it.pkt_seq = seq_pool[$urandom_range(seq_pool.size() - 1)];
          end
        end
        send_item(it, 1'b0);
      end
    end

    drain_block();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("missing_packet_retry_table_core: match");
    end else begin
      $display("missing_packet_retry_table_core: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/mprt_pkg.sv
hdl/mprt_store.sv
hdl/missing_packet_retry_table_core.sv
tb/tb_missing_packet_retry_table_core.sv
